[rtl/core/keyframe_vec3_lerp_blend_top_macros.svh]
// ----------------------------------------------------------------------------
// keyframe_vec3_lerp_blend_top_macros
// assertion macros for the keyframe sampler
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_VEC3_LERP_BLEND_TOP_MACROS_SVH
`define KEYFRAME_VEC3_LERP_BLEND_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define KF_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define KF_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define KF_ASSERT_IMP(label, clk, rst_n, a, c)
`define KF_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

[rtl/core/kfvlb_pkg.sv]
// ----------------------------------------------------------------------------
// kfvlb_pkg
// shared constants and helpers of the keyframe sampler
// ----------------------------------------------------------------------------
package kfvlb_pkg;
	localparam int unsigned ONE_Q16 = 65536;
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// saturate a 34-bit signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [33:0] hi;
		logic signed [33:0] lo;
		hi = 34'sh07FFFFFFF;
		lo = -34'sh080000000;
		if (v > hi) return 32'sh7FFFFFFF;
		else if (v < lo) return 32'sh80000000;
		else return v[31:0];
	endfunction
endpackage

[rtl/core/kfvlb_ram.sv]
// ----------------------------------------------------------------------------
// kfvlb_ram
// generic single-port write, single-port read memory, registered read
// ----------------------------------------------------------------------------
module kfvlb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[rtl/core/kfvlb_div.sv]
// ----------------------------------------------------------------------------
// kfvlb_div
// restoring divider, one quotient bit per cycle, 17-bit quotient
// ----------------------------------------------------------------------------
module kfvlb_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [16:0] quot
);
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] rem_q;
	logic [47:0] sh_q;
	logic [31:0] den_q;
	logic [16:0] quo_q;
	logic [32:0] trial;
	logic [32:0] rem_sh;

	assign rem_sh = {rem_q[31:0], sh_q[47]};
	assign trial  = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// quotient can exceed 17 bits only when num > den, which the search excludes
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= {num, 16'd0};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			sh_q <= {sh_q[46:0], 1'b0};
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[15:0], 1'b0};
			end
		end
	end

	assign quot = quo_q;
endmodule

[rtl/core/kfvlb_lane.sv]
// ----------------------------------------------------------------------------
// kfvlb_lane
// one axis: lerp a..b by f, registered product; f is Q1.16 up to 1.0
// ----------------------------------------------------------------------------
module kfvlb_lane
	import kfvlb_pkg::*;
(
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	input  logic [16:0]        f,
	output logic signed [31:0] res
);
	logic signed [32:0] diff;
	logic signed [50:0] prod_s1;
	logic signed [31:0] a_s1;
	logic signed [33:0] sum;

	assign diff = 33'(b) - 33'(a);

	always_ff @(posedge clk) begin
		prod_s1 <= 51'(diff) * $signed({34'd0, f});
		a_s1    <= a;
	end

	// arithmetic shift floors toward minus infinity
	assign sum = 34'(a_s1) + 34'(prod_s1 >>> 16);
	assign res = sat32(sum);
endmodule

[rtl/core/keyframe_vec3_lerp_blend_top.sv]
// ----------------------------------------------------------------------------
// keyframe_vec3_lerp_blend_top
// keyframe sampler for one 3-vector track with lerp and blend
// ----------------------------------------------------------------------------
// channel | handshake              | payload
// cfg     | cfg_valid / cfg_ready  | cfg_data (key_count)
// in      | in_valid / in_ready    | req_type, key fields, sample fields
// out     | out_valid / out_ready  | out_x/y/z, segment_start, held_last
//
// one request at a time; a key write is stored in the cycle it is accepted
// a sample scans keys one per cycle, reads the segment keys, runs the serial
// divider, then two lerp passes of the axis lanes; held and equal-time
// samples skip the divider
// the result sits in an output register; a stalled output holds the block
// no clearing pass after reset: key stores are undefined until written
`include "keyframe_vec3_lerp_blend_top_macros.svh"
module keyframe_vec3_lerp_blend_top
	import kfvlb_pkg::*;
#(
	parameter int KEY_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [6:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [5:0]         key_index,
	input  logic [31:0]        key_time,
	input  logic signed [31:0] key_x,
	input  logic signed [31:0] key_y,
	input  logic signed [31:0] key_z,
	input  logic [31:0]        sample_time,
	input  logic [16:0]        blend_weight,
	input  logic signed [31:0] prior_x,
	input  logic signed [31:0] prior_y,
	input  logic signed [31:0] prior_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [5:0]         segment_start,
	output logic               held_last
);
	localparam int AW = $clog2(KEY_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_RD0, S_SCAN, S_LD1, S_LD2, S_LD3, S_DIV, S_L1, S_L1W, S_L2, S_L2W,
		S_OUT
	} state_t;

	state_t state_q;
	logic [6:0]  count_q;
	logic [AW:0] last_q;
	logic [AW:0] idx_q;
	logic [31:0] ts_q;
	logic [16:0] w_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic [31:0] prev_t_q, t0_q;
	logic signed [31:0] x0_q, y0_q, z0_q, rx_q, ry_q, rz_q;
	logic [AW-1:0] seg_q;
	logic held_q;
	logic [16:0] frac_q;

	// memories
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   rd_t, rd_x, rd_y, rd_z;
	logic          in_ok;

	assign in_ok = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign we = in_ok && (req_type == REQ_WRITE) && (32'(key_index) < KEY_DEPTH);
	assign waddr = AW'(key_index);

	// scan walks idx; LD1 fetches the start key, later states the end key
	always_comb begin
		case (state_q)
			S_LD1:                     raddr = seg_q;
			S_LD2, S_LD3, S_DIV, S_L1: raddr = seg_q + AW'(1);
			default:                   raddr = idx_q[AW-1:0];
		endcase
	end

	kfvlb_ram #(.WIDTH(32), .DEPTH(KEY_DEPTH)) u_t (.clk, .we, .waddr,
		.wdata(key_time), .raddr, .rdata(rd_t));
	kfvlb_ram #(.WIDTH(32), .DEPTH(KEY_DEPTH)) u_x (.clk, .we, .waddr,
		.wdata(key_x), .raddr, .rdata(rd_x));
	kfvlb_ram #(.WIDTH(32), .DEPTH(KEY_DEPTH)) u_y (.clk, .we, .waddr,
		.wdata(key_y), .raddr, .rdata(rd_y));
	kfvlb_ram #(.WIDTH(32), .DEPTH(KEY_DEPTH)) u_z (.clk, .we, .waddr,
		.wdata(key_z), .raddr, .rdata(rd_z));

	// divider
	logic        div_start, div_done;
	logic [16:0] div_q;
	kfvlb_div u_div (.clk, .arst_n, .start(div_start), .num(ts_q - t0_q),
		.den(rd_t - t0_q), .done(div_done), .quot(div_q));

	// three axis lanes, shared between lerp and blend passes
	logic signed [31:0] la_x, la_y, la_z, lb_x, lb_y, lb_z, lr_x, lr_y, lr_z;
	logic [16:0] lf;
	logic pass2;
	assign pass2 = (state_q == S_L2) || (state_q == S_L2W);
	assign la_x = pass2 ? px_q : x0_q;
	assign la_y = pass2 ? py_q : y0_q;
	assign la_z = pass2 ? pz_q : z0_q;
	assign lb_x = pass2 ? rx_q : rd_x;
	assign lb_y = pass2 ? ry_q : rd_y;
	assign lb_z = pass2 ? rz_q : rd_z;
	assign lf   = pass2 ? w_q : frac_q;
	kfvlb_lane u_lx (.clk, .a(la_x), .b(lb_x), .f(lf), .res(lr_x));
	kfvlb_lane u_ly (.clk, .a(la_y), .b(lb_y), .f(lf), .res(lr_y));
	kfvlb_lane u_lz (.clk, .a(la_z), .b(lb_z), .f(lf), .res(lr_z));

	// merge: segment hit when previous key <= ts <= current key
	// read data trails idx by one, so the segment checked starts at idx - 2
	logic hit;
	assign hit = (prev_t_q <= ts_q) && (rd_t >= ts_q);
	assign div_start = (state_q == S_LD3) && (rd_t != t0_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= 7'd1;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) count_q <= cfg_data;
					if (in_ok && req_type == REQ_SAMPLE) state_q <= S_RD0;
				end
				S_RD0: state_q <= S_SCAN;
				S_SCAN: begin
					if (idx_q >= (AW+1)'(2) && hit) state_q <= S_LD1;
					else if (idx_q > last_q) state_q <= S_LD1;
				end
				S_LD1: state_q <= S_LD2;
				S_LD2: state_q <= held_q ? S_L2 : S_LD3;
				S_LD3: state_q <= (rd_t != t0_q) ? S_DIV : S_L1;
				S_DIV: if (div_done) state_q <= S_L1;
				S_L1:  state_q <= S_L1W;
				S_L1W: state_q <= S_L2;
				S_L2:  state_q <= S_L2W;
				S_L2W: begin
					state_q   <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic [6:0] n_eff;
	always_comb begin
		n_eff = (count_q == 7'd0) ? 7'd1 : count_q;
		if (32'(n_eff) > KEY_DEPTH) n_eff = 7'(KEY_DEPTH);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ts_q   <= sample_time;
				w_q    <= (blend_weight > 17'(ONE_Q16)) ? 17'(ONE_Q16) : blend_weight;
				px_q   <= prior_x;
				py_q   <= prior_y;
				pz_q   <= prior_z;
				idx_q  <= '0;
				last_q <= (AW+1)'(n_eff - 7'd1);
				held_q <= 1'b1;
			end
			S_RD0: idx_q <= idx_q + 1'b1;
			S_SCAN: begin
				prev_t_q <= rd_t;
				if (idx_q >= (AW+1)'(2) && hit) begin
					seg_q  <= AW'(idx_q - (AW+1)'(2));
					held_q <= 1'b0;
				end else if (idx_q > last_q) begin
					seg_q <= last_q[AW-1:0];
				end else idx_q <= idx_q + 1'b1;
			end
			S_LD1: ;
			S_LD2: begin
				// start key; a held key goes straight to the blend pass
				t0_q <= rd_t;
				x0_q <= rd_x;
				y0_q <= rd_y;
				z0_q <= rd_z;
				rx_q <= rd_x;
				ry_q <= rd_y;
				rz_q <= rd_z;
				frac_q <= '0;
			end
			S_DIV: if (div_done) frac_q <= div_q;
			S_L1W: begin
				rx_q <= lr_x;
				ry_q <= lr_y;
				rz_q <= lr_z;
			end
			S_L2W: begin
				out_x <= lr_x;
				out_y <= lr_y;
				out_z <= lr_z;
				segment_start <= 6'(seg_q);
				held_last <= held_q;
			end
			default: ;
		endcase
	end

	`KF_ASSERT_IMP(a_no_in_busy, clk, arst_n, state_q != S_IDLE, !in_ready)
	`KF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`KF_ASSERT_IMP(a_out_state, clk, arst_n, out_valid, state_q == S_OUT)
endmodule
